// File: rtl/pce_pkg.sv
// Package for the piecewise cubic evaluator: field widths, store geometry,
// operation and register codes. No dependencies.
`default_nettype none

package pce_pkg;

  localparam int X_W       = 24;   // sample, signed Q8.16
  localparam int COEF_W    = 32;   // coefficient and result, signed Q16.16
  localparam int SCALE_W   = 32;   // segments per unit of x, unsigned Q16.16
  localparam int SLOT_W    = 8;    // coefficient address
  localparam int SEG_OUT_W = 6;    // reported segment index
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int SEG_COUNT    = 64;
  localparam int LANES        = 4;                    // c0..c3 per segment
  localparam int LANE_W       = $clog2(LANES);
  localparam int ROW_W        = SLOT_W - LANE_W;      // one row per segment
  localparam int ROWS         = 1 << ROW_W;
  localparam int ROW_BITS     = LANES * COEF_W;

  // Integer part of (x - origin) * scale spans bits 57:32 of the product.
  localparam int PROD_W = (X_W + 1) + (SCALE_W + 1);
  localparam int SEG_W  = PROD_W - 32;
  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(SEG_COUNT - 1);

  localparam logic signed [X_W-1:0] ORIGIN_RESET = '0;
  localparam logic [SCALE_W-1:0]    SCALE_RESET  = SCALE_W'(65536);

  typedef enum logic {
    OP_EVAL = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN_ORIGIN = 2'd0,
    REG_SEGMENT_SCALE = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/piecewise_cubic_evaluator.sv
// Piecewise cubic evaluator top level: segment lookup, coefficient row
// memory and the polynomial pipeline. Depends on pce_pkg.
`default_nettype none

// Evaluates y = c0 + c1*x + c2*x^2 + c3*x^3 (Q16.16, saturated) on a sample x
// (Q8.16), with the coefficients of segment trunc((x - domain_origin) *
// segment_scale), clamped to 0..63. One item is taken every clock cycle unless
// back-pressure from out_ready stalls the pipeline and drops in_ready; a
// sample passes stage registers 1 to 6 and then the output register. A load beat
// (operation = 1) writes one coefficient word and gives no result. The
// coefficients sit in one 64 x 128-bit memory, one row per segment with four
// word lanes; loads write their lane in the same pipeline stage in which
// samples read their row, so a load is seen by every later sample and by no
// earlier one. Load every coefficient of a segment before evaluating samples
// that fall in it. Configuration writes are accepted at any time but are
// meant to be made while no item is in flight.
module piecewise_cubic_evaluator
  import pce_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Item channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        operation,
  input  wire logic signed [X_W-1:0]       x_value,
  input  wire logic [SLOT_W-1:0]           coeff_slot,
  input  wire logic signed [COEF_W-1:0]    coeff_word,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [COEF_W-1:0]         y_value,
  output logic [SEG_OUT_W-1:0]             segment_used,
  // Configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers
  logic signed [X_W-1:0] domain_origin;
  logic [SCALE_W-1:0]    segment_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_origin <= ORIGIN_RESET;
      segment_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOMAIN_ORIGIN: domain_origin <= cfg_data[X_W-1:0];
        REG_SEGMENT_SCALE: segment_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6, en_o;

  assign en_o = !out_valid || out_ready;
  assign en6  = !v6 || en_o;
  assign en5  = !v5 || en6;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: captured beat and offset from the domain start
  logic                     s1_op;
  logic signed [X_W-1:0]    s1_x;
  logic signed [X_W:0]      s1_d;
  logic [SLOT_W-1:0]        s1_slot;
  logic signed [COEF_W-1:0] s1_word;
  logic signed [2*X_W-1:0]  s1_xx;

  // Stage 2: segment product and x^2
  logic                     s2_op;
  logic signed [X_W-1:0]    s2_x;
  logic signed [PROD_W-1:0] s2_p;
  logic signed [COEF_W-1:0] s2_x2;
  logic [SLOT_W-1:0]        s2_slot;
  logic signed [COEF_W-1:0] s2_word;
  logic [SEG_W-1:0]         s2_seg;

  // Stage 3: memory address and x^2 * x
  logic                         s3_op;
  logic [ROW_W-1:0]             s3_row;
  logic [LANE_W-1:0]            s3_lane;
  logic signed [COEF_W-1:0]     s3_word;
  logic signed [X_W-1:0]        s3_x;
  logic signed [COEF_W-1:0]     s3_x2;
  logic signed [COEF_W+X_W-1:0] s3_x2x;

  // Stage 4: coefficient row read, x^3 split into high and low halves
  logic [ROW_BITS-1:0]      rd_row;
  logic signed [X_W-1:0]    s4_x;
  logic signed [COEF_W-1:0] s4_x2;
  logic signed [X_W-1:0]    s4_xh;
  logic [15:0]              s4_xl;
  logic [ROW_W-1:0]         s4_seg;
  logic signed [COEF_W-1:0] c0, c1, c2, c3;

  // Stage 5: products
  logic signed [COEF_W-1:0]     s5_c0;
  logic signed [COEF_W+X_W-1:0] s5_p1;
  logic signed [2*COEF_W-1:0]   s5_p2;
  logic signed [COEF_W+X_W-1:0] s5_p3h;
  logic signed [COEF_W+16:0]    s5_p3l;
  logic [ROW_W-1:0]             s5_seg;
  logic signed [COEF_W+X_W-17:0] t1;
  logic signed [COEF_W:0]        t3l;

  // Stage 6: partial sums
  logic signed [COEF_W+X_W-16:0] s6_s01;
  logic signed [2*COEF_W-17:0]   s6_t2;
  logic signed [COEF_W+X_W:0]    s6_t3;
  logic [ROW_W-1:0]              s6_seg;
  logic signed [59:0]            y_sum;
  logic signed [COEF_W-1:0]      y_sat;

  localparam logic signed [COEF_W-1:0] Y_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] Y_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  assign s1_xx = s1_x * s1_x;

  // Clamp the integer part of the product to the segment range.
  always_comb begin
    if (s2_p[PROD_W-1]) begin
      s2_seg = '0;
    end else if (s2_p[PROD_W-1:32] > SEG_MAX) begin
      s2_seg = SEG_MAX;
    end else begin
      s2_seg = s2_p[PROD_W-1:32];
    end
  end

  assign c0 = rd_row[0*COEF_W +: COEF_W];
  assign c1 = rd_row[1*COEF_W +: COEF_W];
  assign c2 = rd_row[2*COEF_W +: COEF_W];
  assign c3 = rd_row[3*COEF_W +: COEF_W];

  assign t1  = s5_p1[COEF_W+X_W-1:16];
  assign t3l = s5_p3l[COEF_W+16:16];

  assign y_sum = 60'(s6_s01) + 60'(s6_t2) + 60'(s6_t3);

  always_comb begin
    if (!y_sum[59] && (|y_sum[58:COEF_W-1])) begin
      y_sat = Y_MAX;
    end else if (y_sum[59] && !(&y_sum[58:COEF_W-1])) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = y_sum[COEF_W-1:0];
    end
  end

  // Valid bits; loads leave the pipeline once they have written the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1 <= in_valid;
      if (en2)  v2 <= v1;
      if (en3)  v3 <= v2;
      if (en4)  v4 <= v3 && (s3_op == OP_EVAL);
      if (en5)  v5 <= v4;
      if (en6)  v6 <= v5;
      if (en_o) out_valid <= v6;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op   <= operation;
      s1_x    <= x_value;
      s1_d    <= (X_W+1)'(x_value) - (X_W+1)'(domain_origin);
      s1_slot <= coeff_slot;
      s1_word <= coeff_word;
    end
    if (en2) begin
      s2_op   <= s1_op;
      s2_x    <= s1_x;
      s2_p    <= s1_d * $signed({1'b0, segment_scale});
      s2_x2   <= s1_xx[2*X_W-1:16];
      s2_slot <= s1_slot;
      s2_word <= s1_word;
    end
    if (en3) begin
      s3_op   <= s2_op;
      s3_row  <= (s2_op == OP_LOAD) ? s2_slot[SLOT_W-1:LANE_W] : s2_seg[ROW_W-1:0];
      s3_lane <= s2_slot[LANE_W-1:0];
      s3_word <= s2_word;
      s3_x    <= s2_x;
      s3_x2   <= s2_x2;
      s3_x2x  <= s2_x2 * s2_x;
    end
    if (en4) begin
      s4_x   <= s3_x;
      s4_x2  <= s3_x2;
      s4_xh  <= s3_x2x[COEF_W+X_W-1:32];
      s4_xl  <= s3_x2x[31:16];
      s4_seg <= s3_row;
    end
    if (en5) begin
      s5_c0  <= c0;
      s5_p1  <= c1 * s4_x;
      s5_p2  <= c2 * s4_x2;
      s5_p3h <= c3 * s4_xh;
      s5_p3l <= c3 * $signed({1'b0, s4_xl});
      s5_seg <= s4_seg;
    end
    if (en6) begin
      s6_s01 <= (COEF_W+X_W-15)'(s5_c0) + (COEF_W+X_W-15)'(t1);
      s6_t2  <= s5_p2[2*COEF_W-1:16];
      s6_t3  <= (COEF_W+X_W+1)'(s5_p3h) + (COEF_W+X_W+1)'(t3l);
      s6_seg <= s5_seg;
    end
    if (en_o) begin
      y_value      <= y_sat;
      segment_used <= SEG_OUT_W'(s6_seg);
    end
  end

  // Coefficient memory: one row per segment, a load writes one word lane.
  // Reads and writes happen in the same stage, so program order is kept.
  logic [ROW_BITS-1:0] coef_mem [ROWS];

  always_ff @(posedge clk) begin
    if (en4) begin
      if (v3 && (s3_op == OP_LOAD)) begin
        coef_mem[s3_row][{s3_lane, 5'd0} +: COEF_W] <= s3_word;
      end
      rd_row <= coef_mem[s3_row];
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted beat did not enter the first stage");

  a_load_retires: assert property (@(posedge clk) disable iff (rst)
    (en4 && v3 && (s3_op == OP_LOAD)) |=> !v4)
    else $error("load beat continued past the memory stage");

  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en5) |=> (v4 && $stable(rd_row)))
    else $error("coefficient row changed while its sample was stalled");

  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    (v6 && out_valid && !out_ready) |=> (v6 && $stable(s6_t3)))
    else $error("sample behind a waiting result was lost");
`endif

endmodule

`default_nettype wire
